@@ rtl/core/enfa_pkg.sv @@
// Shared constants and types for the epsilon-NFA string acceptor.
package enfa_pkg;

  localparam int NUM_STATES = 8;
  localparam int SET_W      = 8;
  localparam int REG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int PIVOT_W    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

  localparam logic [SET_W-1:0] STATE_MASK = SET_W'((2 ** NUM_STATES) - 1);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_EPS_MOVES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MOVES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MOVES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT     = 2'd3;

  typedef enum logic [1:0] {
    SEQ_READY,
    SEQ_LOAD,
    SEQ_RELAX
  } seq_state_e;

  typedef struct packed {
    logic             load;
    logic             relax;
    logic [SET_W-1:0] pivot_sel;
    logic [SET_W-1:0] pivot_row;
    logic             act_we;
    logic             start;
  } cell_ctrl_t;

endpackage

@@ rtl/core/epsilon_nfa_string_acceptor.sv @@
// Top level of the epsilon-NFA string acceptor: registers, cell row, sequencer and output skid.
//
//   Channel  Direction  Handshake                  Word
//   in       input      in_valid_i / in_stall_o    kind_i, character_i
//   out      output     out_valid_o / out_stall_i  string_done_o, accepted_o, invalid_char_o,
//                                                  active_states_o
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One word is accepted per cycle unless stalled; its result is registered in the output stage.
// The state row updates in the cycle a word is accepted, so words follow back to back.
// A write to the epsilon table rebuilds the reachability rows: a load step, then a relax step
// per pivot state, with the input stalled. After reset the rows are already valid.
// A two-entry output stage lets one word be accepted while a result waits to be taken.
module epsilon_nfa_string_acceptor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [7:0]                    character_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          string_done_o,
  output logic                          accepted_o,
  output logic                          invalid_char_o,
  output logic [7:0]                    active_states_o,
  input  logic                          cfg_we_i,
  input  logic [enfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [enfa_pkg::REG_W-1:0]    cfg_data_i
);

  localparam int N = enfa_pkg::NUM_STATES;
  localparam int W = enfa_pkg::SET_W;

  typedef struct packed {
    logic         done;
    logic         acc;
    logic         inv;
    logic [W-1:0] set;
  } result_t;

  logic [enfa_pkg::REG_W-1:0] eps_q;
  logic [enfa_pkg::REG_W-1:0] zero_q;
  logic [enfa_pkg::REG_W-1:0] one_q;
  logic [W-1:0]               acc_mask_q;

  enfa_pkg::seq_state_e seq_q;
  enfa_pkg::seq_state_e seq_d;
  logic [enfa_pkg::PIVOT_W-1:0] pivot_q;
  logic [enfa_pkg::PIVOT_W-1:0] pivot_d;
  logic eps_wr;
  logic busy;

  logic start_q;
  logic bad_q;
  logic bad_d;

  logic [W-1:0] closed_chain [N+1];
  logic [W-1:0] moved_chain  [N+1];
  logic [W-1:0] next_chain   [N+1];
  logic [W-1:0] reach        [N];

  logic [W-1:0] closed;
  logic [W-1:0] moved;
  logic [W-1:0] next_set;
  logic [W-1:0] new_set;
  logic         is_zero;
  logic         is_one;
  logic         in_accept;
  logic         out_take;

  enfa_pkg::cell_ctrl_t ctrl;

  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;

  assign eps_wr = cfg_we_i && (cfg_idx_i == enfa_pkg::REG_EPS_MOVES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q      <= '0;
      zero_q     <= '0;
      one_q      <= '0;
      acc_mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        enfa_pkg::REG_EPS_MOVES:  eps_q      <= cfg_data_i;
        enfa_pkg::REG_ZERO_MOVES: zero_q     <= cfg_data_i;
        enfa_pkg::REG_ONE_MOVES:  one_q      <= cfg_data_i;
        enfa_pkg::REG_ACCEPT:     acc_mask_q <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    seq_d   = seq_q;
    pivot_d = pivot_q;
    unique case (seq_q)
      enfa_pkg::SEQ_READY: begin
        if (eps_wr) begin
          seq_d = enfa_pkg::SEQ_LOAD;
        end
      end
      enfa_pkg::SEQ_LOAD: begin
        pivot_d = '0;
        if (!eps_wr) begin
          seq_d = enfa_pkg::SEQ_RELAX;
        end
      end
      enfa_pkg::SEQ_RELAX: begin
        pivot_d = pivot_q + 1'b1;
        if (eps_wr) begin
          seq_d = enfa_pkg::SEQ_LOAD;
        end else if (pivot_q == enfa_pkg::PIVOT_W'(N - 1)) begin
          seq_d = enfa_pkg::SEQ_READY;
        end
      end
      default: seq_d = enfa_pkg::SEQ_READY;
    endcase
  end

  always_comb begin
    ctrl.load      = (seq_q == enfa_pkg::SEQ_LOAD);
    ctrl.relax     = (seq_q == enfa_pkg::SEQ_RELAX);
    ctrl.pivot_sel = W'(1) << pivot_q;
    ctrl.pivot_row = reach[pivot_q];
    ctrl.act_we    = in_accept && (kind_i == enfa_pkg::KIND_CHAR);
    ctrl.start     = start_q;
    busy           = (seq_q != enfa_pkg::SEQ_READY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= enfa_pkg::SEQ_READY;
      pivot_q <= '0;
    end else begin
      seq_q   <= seq_d;
      pivot_q <= pivot_d;
    end
  end

  assign closed_chain[0] = '0;
  assign moved_chain[0]  = '0;
  assign next_chain[0]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    enfa_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .self_i         (W'(1) << i),
      .eps_row_i      (eps_q[8*i +: W]),
      .move_row_i     (is_one ? one_q[8*i +: W] : zero_q[8*i +: W]),
      .closed_i       (closed),
      .moved_i        (moved),
      .new_set_i      (new_set),
      .closed_chain_i (closed_chain[i]),
      .moved_chain_i  (moved_chain[i]),
      .next_chain_i   (next_chain[i]),
      .closed_chain_o (closed_chain[i+1]),
      .moved_chain_o  (moved_chain[i+1]),
      .next_chain_o   (next_chain[i+1]),
      .reach_o        (reach[i])
    );
  end

  assign closed   = closed_chain[N];
  assign moved    = moved_chain[N];
  assign next_set = next_chain[N];

  assign is_zero = (character_i == enfa_pkg::CHAR_ZERO);
  assign is_one  = (character_i == enfa_pkg::CHAR_ONE);

  always_comb begin
    bad_d   = bad_q;
    new_set = next_set;
    if (!is_zero && !is_one) begin
      bad_d   = 1'b1;
      new_set = closed;
    end
    if (kind_i == enfa_pkg::KIND_END) begin
      res.done = 1'b1;
      res.acc  = !bad_q && (|(closed & acc_mask_q & enfa_pkg::STATE_MASK));
      res.inv  = bad_q;
      res.set  = closed;
    end else begin
      res.done = 1'b0;
      res.acc  = 1'b0;
      res.inv  = bad_d;
      res.set  = new_set;
    end
  end

  assign in_stall_o = busy || skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      bad_q   <= 1'b0;
    end else if (in_accept) begin
      if (kind_i == enfa_pkg::KIND_END) begin
        start_q <= 1'b1;
        bad_q   <= 1'b0;
      end else begin
        start_q <= 1'b0;
        bad_q   <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if ((!out_valid_q || out_take) && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign string_done_o   = out_q.done;
  assign accepted_o      = out_q.acc;
  assign invalid_char_o  = out_q.inv;
  assign active_states_o = out_q.set;

endmodule

@@ rtl/core/enfa_cell.sv @@
// One NFA state cell: its active bit, its epsilon reachability row and its chain stages.
module enfa_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  enfa_pkg::cell_ctrl_t      ctrl_i,
  input  logic [enfa_pkg::SET_W-1:0] self_i,
  input  logic [enfa_pkg::SET_W-1:0] eps_row_i,
  input  logic [enfa_pkg::SET_W-1:0] move_row_i,
  input  logic [enfa_pkg::SET_W-1:0] closed_i,
  input  logic [enfa_pkg::SET_W-1:0] moved_i,
  input  logic [enfa_pkg::SET_W-1:0] new_set_i,
  input  logic [enfa_pkg::SET_W-1:0] closed_chain_i,
  input  logic [enfa_pkg::SET_W-1:0] moved_chain_i,
  input  logic [enfa_pkg::SET_W-1:0] next_chain_i,
  output logic [enfa_pkg::SET_W-1:0] closed_chain_o,
  output logic [enfa_pkg::SET_W-1:0] moved_chain_o,
  output logic [enfa_pkg::SET_W-1:0] next_chain_o,
  output logic [enfa_pkg::SET_W-1:0] reach_o
);

  logic                       act_q;
  logic                       act_d;
  logic [enfa_pkg::SET_W-1:0] row_q;
  logic [enfa_pkg::SET_W-1:0] row_d;
  logic [enfa_pkg::SET_W-1:0] star;
  logic                       act_now;

  assign star    = row_q | self_i;
  assign act_now = ctrl_i.start ? self_i[0] : act_q;
  assign reach_o = row_q;

  assign closed_chain_o = closed_chain_i | (act_now ? star : '0);
  assign moved_chain_o  = moved_chain_i |
                          ((|(closed_i & self_i)) ? (move_row_i & enfa_pkg::STATE_MASK) : '0);
  assign next_chain_o   = next_chain_i | ((|(moved_i & self_i)) ? star : '0);

  always_comb begin
    act_d = act_q;
    if (ctrl_i.act_we) begin
      act_d = |(new_set_i & self_i);
    end
  end

  // Transitive closure update: a state that reaches the pivot also reaches all the pivot reaches.
  always_comb begin
    row_d = row_q;
    if (ctrl_i.load) begin
      row_d = eps_row_i & enfa_pkg::STATE_MASK;
    end else if (ctrl_i.relax && (|(row_q & ctrl_i.pivot_sel))) begin
      row_d = row_q | ctrl_i.pivot_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      row_q <= '0;
    end else begin
      act_q <= act_d;
      row_q <= row_d;
    end
  end

endmodule
